// ----- hdl/cmah_pkg.sv -----
// ----------------------------------------------------------------------------
// cmah_pkg: shared types and constants for the coin/medal input controller
// Word formats, op codes, hopper states and register indexes.
// ----------------------------------------------------------------------------
package cmah_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TIME_W          = 32;
  localparam int CFG_W           = 16;
  localparam int KEY_W           = 11;
  localparam int BTN_W           = 9;
  localparam int CNT_OUT_W       = 16;
  localparam int MEDAL_BIT       = 9;
  localparam int COIN_BIT        = 10;

  localparam logic [CFG_W-1:0] RST_REPEAT_DELAY = 16'd350;
  localparam logic [CFG_W-1:0] RST_MEDAL_REPEAT = 16'd80;
  localparam logic [CFG_W-1:0] RST_COIN_REPEAT  = 16'd100;
  localparam logic [CFG_W-1:0] RST_HOPPER_IVL   = 16'd100;

  typedef enum logic [1:0] {
    OP_POLL       = 2'd0,
    OP_PAYOUT     = 2'd1,
    OP_TAKE_MEDAL = 2'd2,
    OP_TAKE_COIN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_REPEAT_DELAY = 2'd0,
    CFG_MEDAL_REPEAT = 2'd1,
    CFG_COIN_REPEAT  = 2'd2,
    CFG_HOPPER_IVL   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    HOP_IDLE   = 2'd0,
    HOP_PAYING = 2'd1,
    HOP_DONE   = 2'd2
  } hop_mode_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key_bits;
    logic [TIME_W-1:0] now_ms;
    logic [15:0]       payout_count;
  } in_word_t;

  typedef struct packed {
    logic [BTN_W-1:0]     buttons_out;
    logic [CNT_OUT_W-1:0] medal_count;
    logic [CNT_OUT_W-1:0] coin_count;
    logic [1:0]           hopper_status;
    logic [15:0]          medals_paid;
  } out_word_t;

  typedef struct packed {
    logic poll;
    logic take;
    logic down;
  } key_ctl_t;

  typedef struct packed {
    logic poll;
    logic demand;
  } hop_ctl_t;

endpackage

// ----- hdl/cmah_key_rpt.sv -----
// ----------------------------------------------------------------------------
// cmah_key_rpt: typematic repeat counter for one key
// Press adds a pulse; held key adds pulses after the delay at its interval.
// ----------------------------------------------------------------------------
module cmah_key_rpt
  import cmah_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  key_ctl_t               ctl,
  input  logic [TIME_W-1:0]      now_ms,
  input  logic [CFG_W-1:0]       delay_ms,
  input  logic [CFG_W-1:0]       interval_ms,
  output logic [COUNT_WIDTH-1:0] rep_count
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] pending_r, pending_nxt;
  logic                   held_r, held_nxt;
  logic [TIME_W-1:0]      press_r, press_nxt;
  logic [TIME_W-1:0]      repeat_r, repeat_nxt;
  logic [COUNT_WIDTH-1:0] bumped;
  logic [TIME_W-1:0]      since_press, since_repeat;
  logic                   rpt_due;

  assign bumped       = (pending_r != CNT_MAX) ? pending_r + 1'b1 : pending_r;
  assign since_press  = now_ms - press_r;
  assign since_repeat = now_ms - repeat_r;
  // differences wrap modulo 2^32
  assign rpt_due = (since_press >= {{(TIME_W-CFG_W){1'b0}}, delay_ms}) &&
                   (since_repeat >= {{(TIME_W-CFG_W){1'b0}}, interval_ms});

  always_comb begin
    rep_count  = pending_r;
    held_nxt   = held_r;
    press_nxt  = press_r;
    repeat_nxt = repeat_r;
    if (ctl.poll) begin
      held_nxt = ctl.down;
      if (ctl.down && !held_r) begin
        rep_count  = bumped;
        press_nxt  = now_ms;
        repeat_nxt = now_ms;
      end else if (ctl.down && rpt_due) begin
        rep_count  = bumped;
        repeat_nxt = now_ms;
      end
    end
    // take reports the value before clearing
    pending_nxt = ctl.take ? '0 : rep_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      held_r    <= 1'b0;
      press_r   <= '0;
      repeat_r  <= '0;
    end else begin
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
      press_r   <= press_nxt;
      repeat_r  <= repeat_nxt;
    end
  end

  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |=> pending_r == '0)
    else $error("pending count not cleared after take");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.take |=> pending_r >= $past(pending_r))
    else $error("pending count dropped without take");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.poll && !ctl.down) |=> !held_r)
    else $error("key still held after release poll");

endmodule

// ----- hdl/cmah_hopper.sv -----
// ----------------------------------------------------------------------------
// cmah_hopper: virtual medal hopper
// Pays one medal per interval on polls until the demanded count is reached.
// ----------------------------------------------------------------------------
module cmah_hopper
  import cmah_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  hop_ctl_t          ctl,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [15:0]       payout_count,
  input  logic [CFG_W-1:0]  interval_ms,
  output logic [1:0]        hopper_status,
  output logic [15:0]       medals_paid
);

  hop_mode_t         mode_r, mode_nxt;
  logic [15:0]       target_r, target_nxt;
  logic [15:0]       paid_r, paid_nxt;
  logic [TIME_W-1:0] tick_r, tick_nxt;
  logic [15:0]       paid_inc;
  logic              tick_due;

  assign paid_inc = paid_r + 16'd1;
  assign tick_due = (now_ms - tick_r) >= {{(TIME_W-CFG_W){1'b0}}, interval_ms};

  always_comb begin
    mode_nxt   = mode_r;
    target_nxt = target_r;
    paid_nxt   = paid_r;
    tick_nxt   = tick_r;
    if (ctl.demand) begin
      // new demand drops any payout in progress
      target_nxt = payout_count;
      paid_nxt   = '0;
      tick_nxt   = now_ms;
      mode_nxt   = (payout_count != '0) ? HOP_PAYING : HOP_IDLE;
    end else if (ctl.poll) begin
      case (mode_r)
        HOP_PAYING: begin
          if (tick_due) begin
            tick_nxt = now_ms;
            paid_nxt = paid_inc;
            if (paid_inc >= target_r) mode_nxt = HOP_DONE;
          end
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  always_comb begin
    hopper_status = mode_nxt;
    medals_paid   = paid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= HOP_IDLE;
      target_r <= '0;
      paid_r   <= '0;
      tick_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
      paid_r   <= paid_nxt;
      tick_r   <= tick_nxt;
    end
  end

  a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == HOP_DONE |-> paid_r == target_r)
    else $error("hopper finished short of target");

  a_pay_below: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == HOP_PAYING |-> paid_r < target_r)
    else $error("hopper paying past target");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == HOP_IDLE |-> paid_r == '0)
    else $error("idle hopper with nonzero paid count");

endmodule

// ----- hdl/coin_medal_autorepeat_and_hopper.sv -----
// ----------------------------------------------------------------------------
// coin_medal_autorepeat_and_hopper: arcade key input with auto-repeat and hopper
// Top level: config registers, key repeat units, hopper and result register.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word per input word, in the
// cycle after acceptance. All of an item's work (two wrapping time compares
// per key, the hopper interval compare and the counter increments) is done in
// the accept cycle and lands in the state and result registers together, so
// in_ready stays high as long as the result register is empty or being drained.
// Configuration writes take effect on the next word and should be done idle.
// Pending counts are COUNT_WIDTH bits wide and saturate; their low 16 bits
// are reported.
module coin_medal_autorepeat_and_hopper
  import cmah_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] delay_r, medal_ivl_r, coin_ivl_r, hop_ivl_r;
  logic [BTN_W-1:0] buttons_r, buttons_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic     acc;
  op_t      op;
  key_ctl_t medal_ctl, coin_ctl;
  hop_ctl_t hop_ctl;

  logic [COUNT_WIDTH-1:0]           medal_rep, coin_rep;
  logic [COUNT_WIDTH+CNT_OUT_W-1:0] medal_ext, coin_ext;
  logic [1:0]                       hop_status;
  logic [15:0]                      hop_paid;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign op       = op_t'(in_data.op);

  assign medal_ctl.poll = acc && (op == OP_POLL);
  assign medal_ctl.take = acc && (op == OP_TAKE_MEDAL);
  assign medal_ctl.down = in_data.key_bits[MEDAL_BIT];
  assign coin_ctl.poll  = acc && (op == OP_POLL);
  assign coin_ctl.take  = acc && (op == OP_TAKE_COIN);
  assign coin_ctl.down  = in_data.key_bits[COIN_BIT];
  assign hop_ctl.poll   = acc && (op == OP_POLL);
  assign hop_ctl.demand = acc && (op == OP_PAYOUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= RST_REPEAT_DELAY;
      medal_ivl_r <= RST_MEDAL_REPEAT;
      coin_ivl_r  <= RST_COIN_REPEAT;
      hop_ivl_r   <= RST_HOPPER_IVL;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REPEAT_DELAY: delay_r     <= cfg_wdata;
        CFG_MEDAL_REPEAT: medal_ivl_r <= cfg_wdata;
        CFG_COIN_REPEAT:  coin_ivl_r  <= cfg_wdata;
        CFG_HOPPER_IVL:   hop_ivl_r   <= cfg_wdata;
        default:          delay_r     <= delay_r;
      endcase
    end
  end

  cmah_key_rpt #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_medal (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (medal_ctl),
    .now_ms      (in_data.now_ms),
    .delay_ms    (delay_r),
    .interval_ms (medal_ivl_r),
    .rep_count   (medal_rep)
  );

  cmah_key_rpt #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_coin (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (coin_ctl),
    .now_ms      (in_data.now_ms),
    .delay_ms    (delay_r),
    .interval_ms (coin_ivl_r),
    .rep_count   (coin_rep)
  );

  cmah_hopper u_hopper (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (hop_ctl),
    .now_ms        (in_data.now_ms),
    .payout_count  (in_data.payout_count),
    .interval_ms   (hop_ivl_r),
    .hopper_status (hop_status),
    .medals_paid   (hop_paid)
  );

  // zero-extend then take the low bits, so any count width fits the port
  assign medal_ext = {{CNT_OUT_W{1'b0}}, medal_rep};
  assign coin_ext  = {{CNT_OUT_W{1'b0}}, coin_rep};

  always_comb begin
    buttons_nxt   = buttons_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (acc) begin
      if (op == OP_POLL) buttons_nxt = in_data.key_bits[BTN_W-1:0];
      out_valid_nxt              = 1'b1;
      out_data_nxt.buttons_out   = buttons_nxt;
      out_data_nxt.medal_count   = medal_ext[CNT_OUT_W-1:0];
      out_data_nxt.coin_count    = coin_ext[CNT_OUT_W-1:0];
      out_data_nxt.hopper_status = hop_status;
      out_data_nxt.medals_paid   = hop_paid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      buttons_r   <= buttons_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- verif/coin_medal_autorepeat_and_hopper_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coin_medal_autorepeat_and_hopper_test: self-checking bench for the arcade
// key controller. Button latching, medal and coin auto-repeat with wrapping
// time stamps, saturating pulse counters, take-and-clear and the payout hopper
// are predicted word by word and compared with every status word that comes
// back. Both handshakes stall at random, and register settings are changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module coin_medal_autorepeat_and_hopper_test;
  import cmah_pkg::*;

  localparam int QUIET_LIMIT = 1000;  // far above any stall run the idling can cause
  localparam logic [KEY_W-1:0] MEDAL_SW = 11'd1 << MEDAL_BIT;
  localparam logic [KEY_W-1:0] COIN_SW  = 11'd1 << COIN_BIT;

  typedef struct packed {
    logic [15:0] cnt;
    logic        down;
    logic [31:0] press;
    logic [31:0] last;
  } key_track_t;

  class panel_scoreboard;
    logic [15:0] delay_ms, medal_ivl, coin_ivl, hop_ivl;
    logic [8:0]  buttons;
    key_track_t  medal, coin;
    hop_mode_t   hop_state;
    logic [15:0] hop_target, hop_paid;
    logic [31:0] hop_tick;
    out_word_t   status_due[$];
    int          mismatches;
    int          words_checked;

    function new();
      delay_ms   = RST_REPEAT_DELAY;
      medal_ivl  = RST_MEDAL_REPEAT;
      coin_ivl   = RST_COIN_REPEAT;
      hop_ivl    = RST_HOPPER_IVL;
      buttons    = '0;
      medal      = '0;
      coin       = '0;
      hop_state  = HOP_IDLE;
      hop_target = '0;
      hop_paid   = '0;
      hop_tick   = '0;
      mismatches = 0;
      words_checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_REPEAT_DELAY: delay_ms  = val;
        CFG_MEDAL_REPEAT: medal_ivl = val;
        CFG_COIN_REPEAT:  coin_ivl  = val;
        CFG_HOPPER_IVL:   hop_ivl   = val;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return status_due.size();
    endfunction

    // press adds a pulse; a held key adds one once past the delay and interval
    function key_track_t step_key(key_track_t k, logic down, logic [31:0] now,
                                  logic [15:0] ivl);
      logic [31:0] held_for;
      logic [31:0] since_last;
      logic        fire;
      held_for   = now - k.press;
      since_last = now - k.last;
      fire = !k.down || (held_for >= {16'd0, delay_ms} && since_last >= {16'd0, ivl});
      if (down && fire) begin
        if (k.cnt != 16'hFFFF) k.cnt = k.cnt + 16'd1;
        if (!k.down) k.press = now;
        k.last = now;
      end
      k.down = down;
      return k;
    endfunction

    function void note_word(in_word_t w);
      out_word_t   want;
      logic [31:0] since_tick;
      case (op_t'(w.op))
        OP_POLL: begin
          buttons = w.key_bits[BTN_W-1:0];
          medal = step_key(medal, w.key_bits[MEDAL_BIT], w.now_ms, medal_ivl);
          coin  = step_key(coin, w.key_bits[COIN_BIT], w.now_ms, coin_ivl);
          since_tick = w.now_ms - hop_tick;
          if (hop_state == HOP_PAYING && since_tick >= {16'd0, hop_ivl}) begin
            hop_tick = w.now_ms;
            hop_paid = hop_paid + 16'd1;
            if (hop_paid >= hop_target) hop_state = HOP_DONE;
          end
        end
        OP_PAYOUT: begin
          hop_target = w.payout_count;
          hop_paid   = '0;
          hop_tick   = w.now_ms;
          if (w.payout_count != 16'd0) hop_state = HOP_PAYING;
          else hop_state = HOP_IDLE;
        end
        default: ;
      endcase
      want.buttons_out   = buttons;
      want.medal_count   = medal.cnt;
      want.coin_count    = coin.cnt;
      want.hopper_status = hop_state;
      want.medals_paid   = hop_paid;
      // take words report the count before clearing it
      if (op_t'(w.op) == OP_TAKE_MEDAL) medal.cnt = '0;
      else if (op_t'(w.op) == OP_TAKE_COIN) coin.cnt = '0;
      status_due.push_back(want);
    endfunction

    function void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        log_mismatch($sformatf("status word %0d, %s: expected %0h, got %0h",
                               words_checked, field, want, got));
    endfunction

    function void check_status(out_word_t got);
      out_word_t want;
      words_checked++;
      if (status_due.size() == 0) begin
        log_mismatch($sformatf("status word %0d arrived with nothing expected",
                               words_checked));
        return;
      end
      want = status_due.pop_front();
      check_field("buttons_out", 32'(want.buttons_out), 32'(got.buttons_out));
      check_field("medal_count", 32'(want.medal_count), 32'(got.medal_count));
      check_field("coin_count", 32'(want.coin_count), 32'(got.coin_count));
      check_field("hopper_status", 32'(want.hopper_status), 32'(got.hopper_status));
      check_field("medals_paid", 32'(want.medals_paid), 32'(got.medals_paid));
    endfunction

    function void flag_leftovers();
      if (status_due.size() != 0)
        log_mismatch($sformatf("%0d status words never arrived", status_due.size()));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  panel_scoreboard sb = new();

  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          quiet_cycles = 0;
  int          words_sent = 0;
  int          settings_loaded = 0;
  int          time_scale = 350;
  logic [31:0] clock_ms = '0;
  logic        medal_down = 1'b0;
  logic        coin_down = 1'b0;

  coin_medal_autorepeat_and_hopper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_word(input op_t op, input logic [KEY_W-1:0] keys,
                           input logic [31:0] now_ms, input logic [15:0] demand);
    in_word_t w;
    w.op           = op;
    w.key_bits     = keys;
    w.now_ms       = now_ms;
    w.payout_count = demand;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    words_sent++;
  endtask

  // must follow an accepted word, so valid is never dropped and raised in one step
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] delay, input logic [15:0] medal_ms,
                               input logic [15:0] coin_ms, input logic [15:0] hop_ms);
    logic [15:0] vals [4];
    vals = '{delay, medal_ms, coin_ms, hop_ms};
    time_scale = 0;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(cfg_idx_t'(i), vals[i]);
      if (int'(vals[i]) > time_scale) time_scale = int'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [15:0] pick_setting();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 30) return 16'hFFFF;
    if (r < 75) return 16'($urandom_range(1, 400));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_demand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 6));
    if (r < 85) return 16'($urandom_range(7, 60));
    return 16'($urandom);
  endfunction

  // mostly short steps against the current intervals, now and then a jump anywhere
  function automatic void advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return;
    if (r < 80) clock_ms += 32'($urandom_range(0, time_scale / 4 + 3));
    else if (r < 95) clock_ms += 32'($urandom_range(0, time_scale * 2 + 3));
    else clock_ms = $urandom;
  endfunction

  task automatic run_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      advance_clock();
      if (r < 72) begin
        // keys stay down for stretches so the repeat logic gets exercised
        if ($urandom_range(0, 99) < 12) medal_down = ~medal_down;
        if ($urandom_range(0, 99) < 12) coin_down = ~coin_down;
        send_word(OP_POLL, {coin_down, medal_down, 9'($urandom)}, clock_ms,
                  16'($urandom));
      end else if (r < 80) begin
        send_word(OP_PAYOUT, 11'($urandom), clock_ms, pick_demand());
      end else if (r < 90) begin
        send_word(OP_TAKE_MEDAL, 11'($urandom), clock_ms, 16'($urandom));
      end else begin
        send_word(OP_TAKE_COIN, 11'($urandom), clock_ms, 16'($urandom));
      end
      if (i == count / 2 || $urandom_range(0, 299) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  // zero intervals: every held poll bumps both counters and pays one medal,
  // so a short demand finishes and then stays finished
  task automatic run_zero_intervals();
    load_settings(16'd0, 16'd0, 16'd0, 16'd0);
    send_word(OP_TAKE_MEDAL, '0, clock_ms, '0);
    send_word(OP_TAKE_COIN, '0, clock_ms, '0);
    send_word(OP_PAYOUT, '0, $urandom, 16'd25);
    for (int i = 0; i < 40; i++)
      send_word(OP_POLL, {2'b11, 9'($urandom)}, $urandom, 16'($urandom));
    send_word(OP_TAKE_MEDAL, '0, $urandom, '0);
    send_word(OP_TAKE_COIN, '0, $urandom, '0);
    send_word(OP_POLL, '0, $urandom, '0);
    hold_until_drained();
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_status(out_data);
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    snd_idle_pct = 6;
    rcv_idle_pct = 46;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset settings
    send_word(OP_POLL, '0, 32'd0, 16'd0);
    send_word(OP_TAKE_MEDAL, '0, 32'd10, 16'hFFFF);
    send_word(OP_TAKE_COIN, 11'h7FF, 32'd20, '0);
    send_word(OP_POLL, 11'h7FF, 32'd1000, 16'h1234);      // both keys pressed
    send_word(OP_POLL, 11'h7FF, 32'd1100, '0);            // held, before delay
    send_word(OP_POLL, 11'h7FF, 32'd1400, '0);            // delay passed, both repeat
    send_word(OP_POLL, 11'h7FF, 32'd1450, '0);
    send_word(OP_POLL, 11'h7FF, 32'd1480, '0);            // medal repeats, coin not yet
    send_word(OP_PAYOUT, 11'h7FF, 32'd1500, 16'd3);
    send_word(OP_POLL, 11'h155, 32'd1600, '0);            // release, one medal paid
    send_word(OP_PAYOUT, '0, 32'd1650, 16'hFFFF);         // new demand while paying
    send_word(OP_POLL, '0, 32'd1700, '0);
    send_word(OP_PAYOUT, '0, 32'd1800, 16'd0);            // zero demand goes idle
    send_word(OP_PAYOUT, '0, 32'd2000, 16'd2);
    send_word(OP_POLL, 11'h0AA, 32'd2100, '0);
    send_word(OP_POLL, 11'h0AA, 32'd2200, '0);            // finished
    send_word(OP_POLL, 11'h0AA, 32'd2300, '0);            // stays finished
    send_word(OP_TAKE_MEDAL, 11'h7FF, 32'd2310, '0);
    send_word(OP_TAKE_COIN, '0, 32'd2320, '0);
    send_word(OP_POLL, MEDAL_SW, 32'hFFFF_FF00, '0);      // press just before wrap
    send_word(OP_POLL, MEDAL_SW | COIN_SW, 32'h0000_0100, '0);
    send_word(OP_POLL, 11'h1FF, 32'hFFFF_FFFF, '0);
    send_word(OP_TAKE_MEDAL, '0, 32'hFFFF_FFFF, '0);
    hold_until_drained();
    clock_ms = 32'd5000;

    load_settings(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(200);
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(200);

    snd_idle_pct = 46;
    rcv_idle_pct = 6;
    load_settings(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                  16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
    run_random(220);
    load_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting());
    run_random(200);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    load_settings(RST_REPEAT_DELAY, RST_MEDAL_REPEAT, RST_COIN_REPEAT, RST_HOPPER_IVL);
    run_random(200);
    load_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting());
    run_random(160);
    run_zero_intervals();

    repeat (10) @(posedge clk);  // result comes in the cycle after its word; catch strays
    sb.flag_leftovers();
    $display("covered %0d words under %0d register settings, incl. zero intervals",
             words_sent, settings_loaded);
    $display("and a payout run to completion; %0d status words checked, %0d mismatches",
             sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
